>>> src/hswi_pkg.sv
// Package for the hex string to wide integer core.
// Holds character codes, parse phases, flag struct and the hex digit decoder.
// No dependencies.
package hswi_pkg;

    localparam int CHAR_W       = 8;
    localparam int WORD_W       = 64;
    localparam int WORD_INDEX_W = 6;
    localparam int NIBBLE_W     = 4;

    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

    // Letters a to f map to ten and up: the low nibble of the code plus nine.
    localparam logic [NIBBLE_W-1:0] LETTER_OFFSET = 4'd9;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    typedef struct packed {
        logic minus;
        logic bad_char;
        logic overflow;
    } t_flags;

    typedef struct packed {
        logic                valid;
        logic [NIBBLE_W-1:0] value;
    } t_nibble;

    function automatic t_nibble hex_nibble(input logic [CHAR_W-1:0] c);
        t_nibble n;
        n.valid = 1'b1;
        n.value = c[NIBBLE_W-1:0];
        if (c >= CH_ZERO && c <= CH_NINE) begin
            n.value = c[NIBBLE_W-1:0];
        end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                     (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
            n.value = c[NIBBLE_W-1:0] + LETTER_OFFSET;
        end else begin
            n.valid = 1'b0;
        end
        return n;
    endfunction

endpackage

>>> src/hswi_stream_if.sv
// Valid/ready channels of the hex string to wide integer core.
// Depends on hswi_pkg for the field widths.
interface hswi_char_if import hswi_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;
    logic              last_char;

    modport source(output valid, ch, last_char, input ready);
    modport sink(input valid, ch, last_char, output ready);
endinterface

interface hswi_word_if import hswi_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [WORD_W-1:0]       word_value;
    logic                    negative;
    logic                    bad_char;
    logic                    overflow;
    logic                    last_word;

    modport source(output valid, word_index, word_value, negative, bad_char, overflow,
                   last_word, input ready);
    modport sink(input valid, word_index, word_value, negative, bad_char, overflow,
                 last_word, output ready);
endinterface

>>> src/hswi_parser.sv
// Input register and character parser: phase, wide accumulator and flags.
// Depends on hswi_pkg and hswi_char_if.
module hswi_parser import hswi_pkg::*; #(
    parameter int WORDS = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    hswi_char_if.sink               i_char,
    input  logic                    i_load_ok,
    output logic                    o_load,
    output logic [WORDS*WORD_W-1:0] o_acc,
    output t_flags                  o_flags
);

    localparam int ACC_W = WORDS * WORD_W;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_ch;
    logic              r_last;

    t_phase            r_phase, n_phase;
    logic [ACC_W-1:0]  r_acc, n_acc;
    t_flags            r_flags, n_flags;

    logic    step;
    logic    take;
    t_nibble nib;

    // A final character waits here until the word buffer can take its result.
    assign step         = r_in_valid && (!r_last || i_load_ok);
    assign i_char.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_ch   <= i_char.ch;
            r_last <= i_char.last_char;
        end
    end

    assign nib = hex_nibble(r_ch);

    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        n_acc   = r_acc;
        take    = 1'b0;
        unique case (r_phase)
            PH_START: begin
                if (r_ch == CH_MINUS) begin
                    n_flags.minus = 1'b1;
                    n_phase       = PH_SIGNED;
                end else if (r_ch == CH_ZERO) begin
                    n_phase = PH_ZERO;
                end else begin
                    take    = 1'b1;
                    n_phase = PH_DIGITS;
                end
            end
            PH_SIGNED: begin
                if (r_ch == CH_ZERO) begin
                    n_phase = PH_ZERO;
                end else begin
                    take    = 1'b1;
                    n_phase = PH_DIGITS;
                end
            end
            PH_ZERO: begin
                take    = (r_ch != CH_LOWER_X) && (r_ch != CH_UPPER_X);
                n_phase = PH_DIGITS;
            end
            default: begin
                take    = 1'b1;
                n_phase = PH_DIGITS;
            end
        endcase
        if (take) begin
            if (nib.valid) begin
                if (r_acc[ACC_W-1 -: NIBBLE_W] != '0) begin
                    n_flags.overflow = 1'b1;
                end
                n_acc = {r_acc[ACC_W-NIBBLE_W-1:0], nib.value};
            end else begin
                n_flags.bad_char = 1'b1;
            end
        end
    end

    assign o_load  = step && r_last;
    assign o_acc   = n_acc;
    assign o_flags = n_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_load) begin
            r_phase <= PH_START;
            r_acc   <= '0;
            r_flags <= '0;
        end else if (step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_flags <= n_flags;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> (r_phase == PH_START) && (r_acc == '0) && (r_flags == '0))
        else $error("parser state not cleared after final character");
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(r_acc) && $stable(r_phase))
        else $error("parser state moved without a character");
    a_digits_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !r_last && r_phase == PH_DIGITS) |=> (r_phase == PH_DIGITS))
        else $error("parser left the digit phase before the end of the string");
`endif

endmodule

>>> src/hswi_emitter.sv
// Result buffer that sends the parsed value out one 64-bit word per request.
// Depends on hswi_pkg and hswi_word_if.
module hswi_emitter import hswi_pkg::*; #(
    parameter int WORDS = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [WORDS*WORD_W-1:0] i_acc,
    input  t_flags                  i_flags,
    output logic                    o_load_ok,
    hswi_word_if.source             o_word
);

    localparam int                IDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(WORDS - 1);

    logic                r_busy;
    logic [IDX_W-1:0]    r_idx;
    logic [WORD_W-1:0]   r_buf [WORDS];
    logic [WORDS-1:0]    r_nz;
    t_flags              r_flags;

    logic fire;
    logic at_last;

    assign fire      = o_word.valid && o_word.ready;
    assign at_last   = (r_idx == IDX_LAST);
    assign o_load_ok = !r_busy || (fire && at_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fire) begin
            r_busy <= !at_last;
            r_idx  <= at_last ? '0 : r_idx + IDX_W'(1);
        end
    end

    // Words move down one place per request, so word zero is always the one shown.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < WORDS; i++) begin
                r_buf[i] <= i_acc[i*WORD_W +: WORD_W];
                r_nz[i]  <= |i_acc[i*WORD_W +: WORD_W];
            end
            r_flags <= i_flags;
        end else if (fire) begin
            for (int i = 0; i < WORDS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    assign o_word.valid      = r_busy;
    assign o_word.word_index = WORD_INDEX_W'(r_idx);
    assign o_word.word_value = r_buf[0];
    assign o_word.negative   = r_flags.minus && (|r_nz);
    assign o_word.bad_char   = r_flags.bad_char;
    assign o_word.overflow   = r_flags.overflow;
    assign o_word.last_word  = at_last;

`ifndef NO_ASSERTIONS
    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_load_ok)
        else $error("result loaded while the previous run was still going out");
    a_load_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_busy && (r_idx == '0))
        else $error("result run did not start at word zero");
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && at_last && !i_load) |=> !r_busy)
        else $error("buffer still busy after its final word");
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= IDX_LAST))
        else $error("word index beyond the accumulator width");
`endif

endmodule

>>> src/hex_string_to_wide_integer_core.sv
// Top level of the hex string to wide integer core.
// Depends on hswi_pkg, hswi_stream_if, hswi_parser and hswi_emitter.
//
// Usage: characters come in on i_char, one request per character, with
// last_char set on the final character of a string. An optional '-', then an
// optional 0x or 0X prefix, then hex digits of either case are parsed into a
// WORDS x 64-bit magnitude. Other characters set bad_char; nibbles lost off
// the top set overflow. A zero value is always reported with negative low.
// After the final character the magnitude leaves on o_word as WORDS requests,
// least significant word first, each carrying the same flags, with last_word
// set on the top word.
// Throughput is one character per cycle. The first word is valid once the word
// buffer has loaded the parsed value, and one word follows per cycle.
// Characters of the next string are parsed while the words go out; only its
// final character is held in the input register until the word buffer has
// sent its last word, so strings shorter than WORDS characters see stalls.
// A stalled receiver holds the current word and, through that, the input side.
// Reset clears the parse state and drops any words not yet sent.
module hex_string_to_wide_integer_core import hswi_pkg::*; #(
    parameter int WORDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hswi_char_if.sink   i_char,
    hswi_word_if.source o_word
);

    logic                    load;
    logic                    load_ok;
    logic [WORDS*WORD_W-1:0] acc;
    t_flags                  flags;

    hswi_parser #(
        .WORDS(WORDS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_load_ok(load_ok),
        .o_load   (load),
        .o_acc    (acc),
        .o_flags  (flags)
    );

    hswi_emitter #(
        .WORDS(WORDS)
    ) u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_acc    (acc),
        .i_flags  (flags),
        .o_load_ok(load_ok),
        .o_word   (o_word)
    );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for hex_string_to_wide_integer_core.
// Depends on hswi_pkg, the hswi_char_if and hswi_word_if interfaces and the core.
// Sends hex strings and compares every emitted word with a local parser model.
module tb_top import hswi_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS        = 4;
    localparam int ACC_W        = WORDS * WORD_W;
    localparam int RANDOM_CHARS = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [WORD_INDEX_W-1:0] index;
        logic [WORD_W-1:0]       value;
        logic                    negative;
        logic                    bad_char;
        logic                    overflow;
        logic                    last_word;
    } t_word;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hswi_char_if char_if ();
    hswi_word_if word_if ();

    hex_string_to_wide_integer_core #(
        .WORDS(WORDS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_char (char_if),
        .o_word (word_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Parser model state.
    t_phase           parse_phase;
    logic [ACC_W-1:0] magnitude;
    logic             minus_seen;
    logic             bad_seen;
    logic             overflow_seen;

    t_word       word_q[$];
    logic [7:0]  pend_q[$];
    int          fail_count = 0;
    int          burst_left = 0;

    task automatic clear_parser();
        parse_phase   = PH_START;
        magnitude     = '0;
        minus_seen    = 1'b0;
        bad_seen      = 1'b0;
        overflow_seen = 1'b0;
    endtask

    // Shifts in one hex digit, or flags the character as invalid.
    task automatic take_digit(input logic [CHAR_W-1:0] c);
        logic [NIBBLE_W-1:0] d;
        logic                ok;
        ok = 1'b1;
        d  = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = NIBBLE_W'(c - CH_ZERO);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = NIBBLE_W'(c - CH_LOWER_A + 8'd10);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = NIBBLE_W'(c - CH_UPPER_A + 8'd10);
        end else begin
            ok = 1'b0;
        end
        if (!ok) begin
            bad_seen = 1'b1;
        end else begin
            if (magnitude[ACC_W-1 -: NIBBLE_W] != '0) begin
                overflow_seen = 1'b1;
            end
            magnitude = {magnitude[ACC_W-NIBBLE_W-1:0], d};
        end
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic fin);
        t_word w;
        case (parse_phase)
            PH_START: begin
                if (c == CH_MINUS) begin
                    minus_seen  = 1'b1;
                    parse_phase = PH_SIGNED;
                end else if (c == CH_ZERO) begin
                    parse_phase = PH_ZERO;
                end else begin
                    take_digit(c);
                    parse_phase = PH_DIGITS;
                end
            end
            PH_SIGNED: begin
                if (c == CH_ZERO) begin
                    parse_phase = PH_ZERO;
                end else begin
                    take_digit(c);
                    parse_phase = PH_DIGITS;
                end
            end
            PH_ZERO: begin
                // A prefix letter is only legal straight after the first zero.
                if (c != CH_LOWER_X && c != CH_UPPER_X) begin
                    take_digit(c);
                end
                parse_phase = PH_DIGITS;
            end
            default: begin
                take_digit(c);
                parse_phase = PH_DIGITS;
            end
        endcase
        if (fin) begin
            for (int i = 0; i < WORDS; i++) begin
                w.index     = WORD_INDEX_W'(i);
                w.value     = magnitude[i*WORD_W +: WORD_W];
                w.negative  = minus_seen && (magnitude != '0);
                w.bad_char  = bad_seen;
                w.overflow  = overflow_seen;
                w.last_word = (i == WORDS - 1);
                word_q.push_back(w);
            end
            clear_parser();
        end
    endtask

    function automatic logic [CHAR_W-1:0] random_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return CHAR_W'(CH_ZERO + v);
        end
        return CHAR_W'(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + v - 10);
    endfunction

    // Sends one character, opening a random gap whenever a burst runs out.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
        if (burst_left == 0) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        char_if.valid     <= 1'b1;
        char_if.ch        <= c;
        char_if.last_char <= fin;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        burst_left--;
        parse_char(c, fin);
    endtask

    task automatic send_pending();
        int n;
        n = pend_q.size();
        for (int i = 0; i < n; i++) begin
            send_char(pend_q[i], i == n - 1);
        end
        pend_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pend_q.push_back(s[i]);
        end
        send_pending();
    endtask

    task automatic test_directed();
        send_text("0");
        send_text("-");
        send_text("0x");
        send_text("-0X");
        send_text("05");
        send_text("-0");
        send_text("-aF");
        send_text("g");
        send_text("x1");
        send_text("1-2");
        send_text("0x0x");
        pend_q.push_back(8'h00);
        pend_q.push_back(8'hFF);
        send_pending();
    endtask

    task automatic test_wide_values();
        // All ones in every word.
        repeat (WORDS * 16) pend_q.push_back($urandom_range(0, 1) ? CH_LOWER_F : CH_UPPER_F);
        send_pending();
        // Prefixed negative value that is too wide keeps its low bits.
        pend_q.push_back(CH_MINUS);
        pend_q.push_back(CH_ZERO);
        pend_q.push_back(CH_UPPER_X);
        pend_q.push_back(CH_UPPER_A);
        repeat (WORDS * 16) pend_q.push_back(random_hex_char());
        send_pending();
    endtask

    // One- and two-character strings back to back hold the input while words drain.
    task automatic test_short_strings();
        int pick;
        repeat (15) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                pend_q.push_back(CH_MINUS);
            end else if (pick == 1) begin
                pend_q.push_back(CHAR_W'($urandom_range(0, 255)));
            end else begin
                pend_q.push_back(random_hex_char());
            end
            if ($urandom_range(0, 2) == 0) begin
                pend_q.push_back(random_hex_char());
            end
            send_pending();
        end
    endtask

    task automatic test_random();
        int sent_chars;
        int kind;
        int ndig;
        int pos;
        sent_chars = 0;
        while (sent_chars < RANDOM_CHARS) begin
            kind = $urandom_range(0, 9);
            if (kind < 9) begin
                if ($urandom_range(0, 1)) begin
                    pend_q.push_back(CH_MINUS);
                end
                if ($urandom_range(0, 2) == 0) begin
                    pend_q.push_back(CH_ZERO);
                    pend_q.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
                end
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) pend_q.push_back(CH_ZERO);
                end
                ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(0, 12);
                repeat (ndig) pend_q.push_back(random_hex_char());
                if (pend_q.size() == 0) begin
                    pend_q.push_back(random_hex_char());
                end
                // Corrupt some strings with a stray byte or a misplaced sign or prefix.
                if (kind >= 7) begin
                    pos = $urandom_range(0, pend_q.size() - 1);
                    case ($urandom_range(0, 3))
                        0:       pend_q[pos] = CH_MINUS;
                        1:       pend_q[pos] = CH_LOWER_X;
                        2:       pend_q.insert(pos, CH_UPPER_X);
                        default: pend_q[pos] = CHAR_W'($urandom_range(0, 255));
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 6)) pend_q.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            sent_chars += pend_q.size();
            send_pending();
        end
    endtask

    function automatic void check_field(input string name, input int idx,
                                        input logic [WORD_W-1:0] exp,
                                        input logic [WORD_W-1:0] act);
        if (exp !== act) begin
            $display("%0t: word %0d %s mismatch, expected %h, actual %h",
                     $realtime, idx, name, exp, act);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_word w;
        int    idx;
        if (i_rst_n && word_if.valid && word_if.ready) begin
            if (word_q.size() == 0) begin
                $display("%0t: word request with nothing expected, index %0d value %h",
                         $realtime, word_if.word_index, word_if.word_value);
                fail_count++;
            end else begin
                w   = word_q.pop_front();
                idx = int'(w.index);
                check_field("word_index", idx, WORD_W'(w.index),
                            WORD_W'(word_if.word_index));
                check_field("word_value", idx, w.value, word_if.word_value);
                check_field("negative", idx, WORD_W'(w.negative), WORD_W'(word_if.negative));
                check_field("bad_char", idx, WORD_W'(w.bad_char), WORD_W'(word_if.bad_char));
                check_field("overflow", idx, WORD_W'(w.overflow), WORD_W'(word_if.overflow));
                check_field("last_word", idx, WORD_W'(w.last_word),
                            WORD_W'(word_if.last_word));
            end
        end
    end

    // Receiver backpressure: the pattern switches at random among always-ready, coin-flip, slow and periodic modes.
    initial begin : ready_driver
        t_rx_mode mode;
        int       left;
        int       cnt;
        mode = RX_ALWAYS;
        left = 0;
        cnt  = 0;
        word_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                left = $urandom_range(20, 150);
            end
            left--;
            cnt++;
            case (mode)
                RX_ALWAYS:   word_if.ready <= 1'b1;
                RX_COIN:     word_if.ready <= 1'($urandom_range(0, 1));
                RX_SLOW:     word_if.ready <= ($urandom_range(0, 3) == 0);
                default:     word_if.ready <= ((cnt % 5) < 3);
            endcase
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout with %0d words still expected", $realtime, word_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        char_if.valid     <= 1'b0;
        char_if.ch        <= '0;
        char_if.last_char <= 1'b0;
        clear_parser();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_wide_values();
        test_short_strings();
        test_random();

        char_if.valid <= 1'b0;
        while (word_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
